// File: rtl/bbe_pkg.sv
// Shared constants, types and tables of the blob bounding box extractor.
package bbe_pkg;

    localparam int MAX_WIDTH  = 128;
    localparam int MAX_HEIGHT = 128;
    localparam int MAX_BLOBS  = 64;
    localparam int NPIX       = MAX_WIDTH * MAX_HEIGHT;
    localparam int XW         = $clog2(MAX_WIDTH);
    localparam int YW         = $clog2(MAX_HEIGHT);
    localparam int ADDR_W     = XW + YW;
    localparam int CNT_W      = ADDR_W + 1;
    localparam int SUM_W      = CNT_W + 7;
    localparam int NUM_W      = SUM_W + 4;
    localparam int Q_W        = 12;
    localparam int REP_W      = 7;
    localparam int QDEPTH     = 4;

    localparam logic [2:0] CFG_WIDTH     = 3'd0;
    localparam logic [2:0] CFG_HEIGHT    = 3'd1;
    localparam logic [2:0] CFG_ALPHA     = 3'd2;
    localparam logic [2:0] CFG_MIN_PIX   = 3'd3;
    localparam logic [2:0] CFG_PIVOT     = 3'd4;

    localparam logic signed [1:0] STEP_DX [8] = '{2'sd0, 2'sd0, 2'sd1, -2'sd1,
                                                  2'sd1, 2'sd1, -2'sd1, -2'sd1};
    localparam logic signed [1:0] STEP_DY [8] = '{2'sd1, -2'sd1, 2'sd0, 2'sd0,
                                                  2'sd1, -2'sd1, 2'sd1, -2'sd1};

    typedef struct packed {
        logic              fg;
        logic              eoi;
        logic [ADDR_W-1:0] addr;
    } t_qitem;

    typedef struct packed {
        logic           blob_valid;
        logic [5:0]     blob_index;
        logic [6:0]     box_x;
        logic [6:0]     box_y;
        logic [7:0]     box_width;
        logic [7:0]     box_height;
        logic [Q_W-1:0] pivot_x_q4;
        logic [Q_W-1:0] pivot_y_q4;
        logic [14:0]    pixel_total;
        logic           overflow;
        logic           last;
    } t_result;

    typedef enum logic [4:0] {
        S_LOAD, S_SCAN_RD, S_SCAN_CHK, S_POP, S_POP_W, S_NB_RD, S_NB_CHK,
        S_FIN, S_MUL, S_DIVX_GO, S_DIVX_W, S_DIVY_GO, S_DIVY_W, S_STORE,
        S_ADV, S_END
    } t_fill_state;

endpackage

// File: rtl/bbe_front.sv
// Pixel classifier and raster address generator feeding the fill queue.
module bbe_front import bbe_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [7:0]   i_width,
    input  logic [7:0]   i_height,
    input  logic [7:0]   i_alpha_threshold,
    input  logic         i_s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  i_s_tdata,
    input  logic         i_q_full,
    output logic         o_push,
    output t_qitem       o_item
);

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [XW-1:0]    r_x, n_x;
    logic [YW-1:0]    r_y, n_y;
    logic [7:0]       red, green, blue, alpha;
    logic             guide, last_px;
    logic [CNT_W-1:0] total;

    assign red   = i_s_tdata[7:0];
    assign green = i_s_tdata[15:8];
    assign blue  = i_s_tdata[23:16];
    assign alpha = i_s_tdata[31:24];
    assign guide = (red > 8'd200 && green < 8'd50 && blue > 8'd200) ||
                   (red < 8'd50 && green > 8'd200 && blue > 8'd200);
    assign total   = CNT_W'(i_width * i_height);
    assign last_px = (r_cnt + CNT_W'(1)) >= total;

    assign s_tready    = !i_q_full;
    assign o_push      = i_s_tvalid && !i_q_full;
    assign o_item.fg   = (alpha > i_alpha_threshold) && !guide;
    assign o_item.eoi  = last_px;
    assign o_item.addr = {r_y, r_x};

    always_comb begin
        n_cnt = r_cnt;
        n_x   = r_x;
        n_y   = r_y;
        if (o_push) begin
            if (last_px) begin
                n_cnt = '0;
                n_x   = '0;
                n_y   = '0;
            end else begin
                n_cnt = r_cnt + CNT_W'(1);
                if ({1'b0, r_x} + 9'd1 >= {1'b0, i_width}) begin
                    n_x = '0;
                    n_y = r_y + YW'(1);
                end else begin
                    n_x = r_x + XW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_x   <= '0;
            r_y   <= '0;
        end else begin
            r_cnt <= n_cnt;
            r_x   <= n_x;
            r_y   <= n_y;
        end
    end

endmodule

// File: rtl/bbe_queue.sv
// Short first-in first-out queue between the classifier and the fill engine.
module bbe_queue import bbe_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_qitem i_item,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_empty,
    output t_qitem o_item
);

    localparam int PW = $clog2(QDEPTH);

    t_qitem          r_mem [QDEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [PW:0]     r_n;
    logic            do_push, do_pop;

    assign o_full  = r_n == (PW+1)'(QDEPTH);
    assign o_empty = r_n == '0;
    assign o_item  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_n  <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + PW'(1);
            end
            r_n <= r_n + (PW+1)'(do_push) - (PW+1)'(do_pop);
        end
    end

endmodule

// File: rtl/bbe_div.sv
// Restoring divider, one quotient bit per cycle, for the center of mass pivot.
module bbe_div import bbe_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [CNT_W-1:0] i_den,
    output logic             o_done,
    output logic [Q_W-1:0]   o_quot
);

    localparam int SW = $clog2(NUM_W + 1);

    logic             r_busy, r_done;
    logic [SW-1:0]    r_step;
    logic [NUM_W-1:0] r_num;
    logic [CNT_W-1:0] r_rem, r_den;
    logic [CNT_W:0]   trial;
    logic             fits;

    assign trial  = {r_rem, r_num[NUM_W-1]};
    assign fits   = trial >= {1'b0, r_den};
    assign o_done = r_done;
    assign o_quot = r_num[Q_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? CNT_W'(trial - {1'b0, r_den}) : trial[CNT_W-1:0];
            r_num <= {r_num[NUM_W-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + SW'(1);
                if (r_step == SW'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// File: rtl/bbe_fill.sv
// Mask store, flood fill engine, island statistics and result register.
module bbe_fill import bbe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_width,
    input  logic [7:0]  i_height,
    input  logic [14:0] i_min_pixels,
    input  logic        i_pivot_mode,
    input  logic        i_q_empty,
    input  t_qitem      i_q_item,
    output logic        o_q_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output t_result     o_result
);

    t_fill_state      r_state, n_state;
    logic [1:0]       r_mask [NPIX];
    logic [ADDR_W-1:0] r_stack [NPIX];
    logic [1:0]       r_mem_q;
    logic [ADDR_W-1:0] r_stk_q;

    logic             mem_we, stk_we;
    logic [ADDR_W-1:0] mem_wa, mem_ra, stk_wa, stk_ra, stk_wd;
    logic [1:0]       mem_wd;

    logic [XW-1:0]    r_sx, r_cx, r_minx, r_maxx;
    logic [YW-1:0]    r_sy, r_cy, r_miny, r_maxy;
    logic [2:0]       r_nb;
    logic [CNT_W-1:0] r_sp, r_cnt;
    logic [SUM_W-1:0] r_sumx, r_sumy;
    logic [SUM_W:0]   r_prodx, r_prody;
    logic [REP_W-1:0] r_rep;
    logic             r_extra, r_pend_v, r_out_v;
    logic [Q_W-1:0]   r_px, r_py;
    t_result          r_pend, r_out, new_res, end_res;

    logic             do_push, do_pop_px, do_start, do_store, do_end, out_free;
    logic signed [8:0] nx, ny;
    logic             nb_in;
    logic [ADDR_W-1:0] nb_addr;
    logic             div_start, div_done;
    logic [NUM_W-1:0] div_num;
    logic [Q_W-1:0]   div_q;
    logic [SUM_W:0]   diffx, diffy;
    logic [YW-1:0]    py_c;
    logic [XW-1:0]    px_c;

    assign out_free = !r_out_v || i_ready;
    assign o_valid  = r_out_v;
    assign o_result = r_out;

    assign nx = $signed({2'b00, r_cx}) + 9'(STEP_DX[r_nb]);
    assign ny = $signed({2'b00, r_cy}) + 9'(STEP_DY[r_nb]);
    assign nb_in = !nx[8] && !ny[8] && (nx[7:0] < i_width) && (ny[7:0] < i_height);
    assign nb_addr = {ny[YW-1:0], nx[XW-1:0]};
    assign py_c = r_stk_q[ADDR_W-1:XW];
    assign px_c = r_stk_q[XW-1:0];

    assign diffx = {1'b0, r_sumx} - r_prodx;
    assign diffy = {1'b0, r_sumy} - r_prody;

    always_comb begin
        new_res             = '0;
        new_res.blob_valid  = 1'b1;
        new_res.blob_index  = r_rep[5:0];
        new_res.box_x       = 7'(r_minx);
        new_res.box_y       = 7'(r_miny);
        new_res.box_width   = 8'({1'b0, r_maxx} - {1'b0, r_minx} + 8'd1);
        new_res.box_height  = 8'({1'b0, r_maxy} - {1'b0, r_miny} + 8'd1);
        new_res.pivot_x_q4  = r_px;
        new_res.pivot_y_q4  = r_py;
        new_res.pixel_total = 15'(r_cnt);
    end

    always_comb begin
        if (r_pend_v) begin
            end_res          = r_pend;
            end_res.overflow = r_extra;
        end else begin
            end_res = '0;
        end
        end_res.last = 1'b1;
    end

    always_comb begin
        n_state   = r_state;
        mem_we    = 1'b0;
        mem_wa    = '0;
        mem_wd    = '0;
        mem_ra    = '0;
        stk_we    = 1'b0;
        stk_wa    = r_sp[ADDR_W-1:0];
        stk_wd    = '0;
        stk_ra    = '0;
        o_q_pop   = 1'b0;
        do_push   = 1'b0;
        do_pop_px = 1'b0;
        do_start  = 1'b0;
        do_store  = 1'b0;
        do_end    = 1'b0;
        div_start = 1'b0;
        div_num   = {diffx[SUM_W-1:0], 4'b0000};
        unique case (r_state)
            S_LOAD: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    mem_we  = 1'b1;
                    mem_wa  = i_q_item.addr;
                    mem_wd  = {i_q_item.fg, 1'b0};
                    if (i_q_item.eoi) begin
                        n_state = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD: begin
                mem_ra  = {r_sy, r_sx};
                n_state = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (r_mem_q[1] && !r_mem_q[0]) begin
                    mem_we   = 1'b1;
                    mem_wa   = {r_sy, r_sx};
                    mem_wd   = 2'b11;
                    stk_we   = 1'b1;
                    stk_wd   = {r_sy, r_sx};
                    do_push  = 1'b1;
                    do_start = 1'b1;
                    n_state  = S_POP;
                end else begin
                    n_state = S_ADV;
                end
            end
            S_POP: begin
                if (r_sp == '0) begin
                    n_state = S_FIN;
                end else begin
                    stk_ra  = ADDR_W'(r_sp - CNT_W'(1));
                    n_state = S_POP_W;
                end
            end
            S_POP_W: begin
                do_pop_px = 1'b1;
                n_state   = S_NB_RD;
            end
            S_NB_RD: begin
                if (nb_in) begin
                    mem_ra  = nb_addr;
                    n_state = S_NB_CHK;
                end else if (r_nb == 3'd7) begin
                    n_state = S_POP;
                end
            end
            S_NB_CHK: begin
                if (r_mem_q[1] && !r_mem_q[0]) begin
                    mem_we  = 1'b1;
                    mem_wa  = nb_addr;
                    mem_wd  = 2'b11;
                    stk_we  = 1'b1;
                    stk_wd  = nb_addr;
                    do_push = 1'b1;
                end
                n_state = (r_nb == 3'd7) ? S_POP : S_NB_RD;
            end
            S_FIN: begin
                if (r_cnt > i_min_pixels) begin
                    if (r_rep < REP_W'(MAX_BLOBS)) begin
                        n_state = i_pivot_mode ? S_STORE : S_MUL;
                    end else begin
                        n_state = S_ADV;
                    end
                end else begin
                    n_state = S_ADV;
                end
            end
            S_MUL: begin
                n_state = S_DIVX_GO;
            end
            S_DIVX_GO: begin
                div_start = 1'b1;
                n_state   = S_DIVX_W;
            end
            S_DIVX_W: begin
                if (div_done) begin
                    n_state = S_DIVY_GO;
                end
            end
            S_DIVY_GO: begin
                div_start = 1'b1;
                div_num   = {diffy[SUM_W-1:0], 4'b0000};
                n_state   = S_DIVY_W;
            end
            S_DIVY_W: begin
                if (div_done) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                if (!r_pend_v || out_free) begin
                    do_store = 1'b1;
                    n_state  = S_ADV;
                end
            end
            S_ADV: begin
                if ({1'b0, r_sx} + 9'd1 >= {1'b0, i_width} &&
                    {1'b0, r_sy} + 9'd1 >= {1'b0, i_height}) begin
                    n_state = S_END;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_END: begin
                if (out_free) begin
                    do_end  = 1'b1;
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mask[mem_wa] <= mem_wd;
        end
        r_mem_q <= r_mask[mem_ra];
        if (stk_we) begin
            r_stack[stk_wa] <= stk_wd;
        end
        r_stk_q <= r_stack[stk_ra];
    end

    always_ff @(posedge i_clk) begin
        if (do_start) begin
            r_minx <= r_sx;
            r_maxx <= r_sx;
            r_miny <= r_sy;
            r_maxy <= r_sy;
            r_sumx <= '0;
            r_sumy <= '0;
            r_cnt  <= '0;
        end else if (do_pop_px) begin
            r_cx   <= px_c;
            r_cy   <= py_c;
            r_nb   <= '0;
            r_minx <= (px_c < r_minx) ? px_c : r_minx;
            r_maxx <= (px_c > r_maxx) ? px_c : r_maxx;
            r_miny <= (py_c < r_miny) ? py_c : r_miny;
            r_maxy <= (py_c > r_maxy) ? py_c : r_maxy;
            r_sumx <= r_sumx + SUM_W'(px_c);
            r_sumy <= r_sumy + SUM_W'(py_c);
            r_cnt  <= r_cnt + CNT_W'(1);
        end else if ((r_state == S_NB_CHK) ||
                     (r_state == S_NB_RD && !nb_in && r_nb != 3'd7)) begin
            r_nb <= r_nb + 3'd1;
        end
        if (r_state == S_MUL) begin
            r_prodx <= (SUM_W+1)'(r_minx * r_cnt);
            r_prody <= (SUM_W+1)'(r_miny * r_cnt);
        end
        if (r_state == S_FIN) begin
            r_px <= Q_W'({1'b0, r_maxx} - {1'b0, r_minx} + 8'd1) << 3;
            r_py <= Q_W'({1'b0, r_maxy} - {1'b0, r_miny} + 8'd1) << 4;
        end
        if (r_state == S_DIVX_W && div_done) begin
            r_px <= div_q;
        end
        if (r_state == S_DIVY_W && div_done) begin
            r_py <= div_q;
        end
        if (do_store) begin
            r_pend <= new_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_sp     <= '0;
            r_sx     <= '0;
            r_sy     <= '0;
            r_rep    <= '0;
            r_extra  <= 1'b0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
            r_out    <= '0;
        end else begin
            r_state <= n_state;
            if (do_push) begin
                r_sp <= r_sp + CNT_W'(1);
            end else if (r_state == S_POP && r_sp != '0) begin
                r_sp <= r_sp - CNT_W'(1);
            end
            if (r_state == S_LOAD) begin
                r_sx <= '0;
                r_sy <= '0;
            end else if (r_state == S_ADV) begin
                if ({1'b0, r_sx} + 9'd1 >= {1'b0, i_width}) begin
                    r_sx <= '0;
                    r_sy <= r_sy + YW'(1);
                end else begin
                    r_sx <= r_sx + XW'(1);
                end
            end
            if (r_state == S_FIN && r_cnt > i_min_pixels &&
                r_rep >= REP_W'(MAX_BLOBS)) begin
                r_extra <= 1'b1;
            end
            if ((do_store && r_pend_v) || do_end) begin
                r_out_v <= 1'b1;
            end else if (r_out_v && i_ready) begin
                r_out_v <= 1'b0;
            end
            if (do_store) begin
                r_rep    <= r_rep + REP_W'(1);
                r_pend_v <= 1'b1;
                if (r_pend_v) begin
                    r_out <= r_pend;
                end
            end
            if (do_end) begin
                r_pend_v <= 1'b0;
                r_extra  <= 1'b0;
                r_rep    <= '0;
                r_sp     <= '0;
                r_out    <= end_res;
            end
        end
    end

    bbe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_cnt),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

endmodule

// File: rtl/blob_bounding_box_extractor_unit.sv
// Top level of the blob bounding box extractor with its configuration registers.
// Pixels are taken one per cycle while the image loads and the input queue has room;
// after the last pixel the fill engine scans the image and floods each 8-connected
// island through its mask memory, and in center of mass mode it runs two 26-step
// pivot divisions for each reported island. Results leave through a one-entry
// output register; no pixels are accepted while the fill runs once the four-entry
// input queue is full.
module blob_bounding_box_extractor_unit import bbe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [14:0] i_cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // red, green, blue, alpha
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // blob_index, box_x, box_y, box_width, box_height,
                                   // pivot_x_q4, pivot_y_q4, pixel_total, overflow
    output logic        m_tuser,   // blob_valid
    output logic        m_tlast
);

    logic [7:0]  r_width, r_height, r_alpha;
    logic [14:0] r_min_pix;
    logic        r_pivot;
    logic [7:0]  width_c, height_c;
    logic        q_push, q_pop, q_full, q_empty;
    t_qitem      q_in, q_out;
    t_result     res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= 8'(MAX_WIDTH);
            r_height  <= 8'(MAX_HEIGHT);
            r_alpha   <= 8'd30;
            r_min_pix <= 15'd5;
            r_pivot   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_WIDTH:   r_width   <= i_cfg_data[7:0];
                CFG_HEIGHT:  r_height  <= i_cfg_data[7:0];
                CFG_ALPHA:   r_alpha   <= i_cfg_data[7:0];
                CFG_MIN_PIX: r_min_pix <= i_cfg_data;
                CFG_PIVOT:   r_pivot   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign width_c  = (r_width == 8'd0) ? 8'd1 :
                      ({1'b0, r_width} > 9'(MAX_WIDTH)) ? 8'(MAX_WIDTH) : r_width;
    assign height_c = (r_height == 8'd0) ? 8'd1 :
                      ({1'b0, r_height} > 9'(MAX_HEIGHT)) ? 8'(MAX_HEIGHT) : r_height;

    bbe_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_width           (width_c),
        .i_height          (height_c),
        .i_alpha_threshold (r_alpha),
        .i_s_tvalid        (s_tvalid),
        .s_tready          (s_tready),
        .i_s_tdata         (s_tdata),
        .i_q_full          (q_full),
        .o_push            (q_push),
        .o_item            (q_in)
    );

    bbe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_item  (q_out)
    );

    bbe_fill u_fill (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_width      (width_c),
        .i_height     (height_c),
        .i_min_pixels (r_min_pix),
        .i_pivot_mode (r_pivot),
        .i_q_empty    (q_empty),
        .i_q_item     (q_out),
        .o_q_pop      (q_pop),
        .o_valid      (m_tvalid),
        .i_ready      (m_tready),
        .o_result     (res)
    );

    assign m_tuser = res.blob_valid;
    assign m_tlast = res.last;
    assign m_tdata = {4'b0000, res.overflow, res.pixel_total, res.pivot_y_q4,
                      res.pivot_x_q4, res.box_height, res.box_width, res.box_y,
                      res.box_x, res.blob_index};

endmodule
